>>> hw/rtl/ucs_pkg.sv
// Shared types, constants and decode functions for the UTF-8 codepoint splitter.
// Used by ucs_ctrl, ucs_datapath and utf8_codepoint_splitter; no dependencies.
package ucs_pkg;

    localparam int BUF_DEPTH  = 4;
    localparam int OUT_DATA_W = 56;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [7:0]  LEAD2_MARK     = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK     = 8'hE0;
    localparam logic [7:0]  LEAD4_MARK     = 8'hF0;
    localparam logic [4:0]  LEAD4_PREFIX   = 5'h1E;
    localparam logic [7:0]  CONT_MASK      = 8'h3F;
    localparam logic [7:0]  CONT_MARK      = 8'h80;

    typedef logic [BUF_DEPTH-1:0][7:0] buf_t;

    typedef struct packed {
        logic load;     // take the input transaction into the buffer
        logic step;     // emit one segment and shift the buffer
    } ucs_cmd_t;

    typedef struct packed {
        logic       hold_seq;   // buffer head is an unfinished good sequence
        logic       is_last;    // segment at the head is the last of this run
        logic       out_free;   // output register can take a segment
        logic       eot;        // the run in progress ended the text
        logic [2:0] count;      // bytes in the buffer
    } ucs_stat_t;

    typedef struct packed {
        logic       hold_seq;
        logic       raw;
        logic [2:0] used;
        logic [2:0] len;
    } dec_t;

    function automatic logic [2:0] seq_len(logic [7:0] c0);
        logic [2:0] l;
        if (c0[7] == 1'b0)
            l = 3'd1;
        else if (c0[7:5] == LEAD2_MARK[7:5])
            l = 3'd2;
        else if (c0[7:4] == LEAD3_MARK[7:4])
            l = 3'd3;
        else if (c0[7:3] == LEAD4_PREFIX)
            l = 3'd4;
        else
            l = 3'd0;
        return l;
    endfunction

    // Classify the sequence at the head of a buffer holding n bytes.
    function automatic dec_t decide(buf_t b, logic [2:0] n, logic eot);
        dec_t       d;
        logic [2:0] sl;
        logic [2:0] avail;
        logic       bad;
        sl    = seq_len(b[0]);
        avail = (n < sl) ? n : sl;
        bad   = 1'b0;
        for (int i = 1; i < BUF_DEPTH; i++)
        begin
            if ((3'(i) < avail) && ((b[i] & ~CONT_MASK) != CONT_MARK))
                bad = 1'b1;
        end
        d.len      = sl;
        d.raw      = (sl == 3'd0) || bad || ((n < sl) && eot);
        d.hold_seq = (n != 3'd0) && (sl != 3'd0) && !bad && (n < sl) && !eot;
        d.used     = d.raw ? 3'd1 : sl;
        return d;
    endfunction

endpackage

>>> hw/rtl/ucs_ctrl.sv
// Controller state machine for the UTF-8 codepoint splitter.
// Depends on ucs_pkg; drives ucs_datapath through command/status structs.
module ucs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ucs_pkg::ucs_stat_t stat,
    output ucs_pkg::ucs_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // unfinished sequence: keep the bytes and wait for more input
                if (stat.hold_seq)
                    state_next = ST_IDLE;
                else if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hw/rtl/ucs_datapath.sv
// Datapath for the UTF-8 codepoint splitter: byte buffer, decode, re-encode
// and output register. Depends on ucs_pkg; commanded by ucs_ctrl.
module ucs_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ucs_pkg::ucs_cmd_t                     cmd,
    input  logic [7:0]                            in_byte,
    input  logic                                  in_eot,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [ucs_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    output ucs_pkg::ucs_stat_t                    stat
);

    ucs_pkg::buf_t buf_reg;
    ucs_pkg::buf_t buf_next;
    logic [2:0]    count_reg;
    logic [2:0]    count_next;
    logic          eot_reg;

    logic          out_valid_reg;
    logic [2:0]    out_len_reg;
    logic [31:0]   out_bytes_reg;
    logic [20:0]   out_cp_reg;
    logic          out_raw_reg;
    logic          out_last_reg;

    ucs_pkg::dec_t dec;
    ucs_pkg::dec_t dec_after;
    ucs_pkg::buf_t buf_shift;
    logic [2:0]    count_after;
    logic [20:0]   cp;
    logic [2:0]    seg_len;
    logic [31:0]   seg_bytes;
    logic [20:0]   seg_cp;
    logic [7:0]    c0;

    assign c0          = buf_reg[0];
    assign dec         = ucs_pkg::decide(buf_reg, count_reg, eot_reg);
    assign buf_shift   = ucs_pkg::buf_t'(buf_reg >> (6'(dec.used) << 3));
    assign count_after = count_reg - dec.used;
    // look one segment ahead to tell whether this one closes the run
    assign dec_after   = ucs_pkg::decide(buf_shift, count_after, eot_reg);

    always_comb
    begin
        case (dec.len)
            3'd2:    cp = {10'd0, c0[4:0], buf_reg[1][5:0]};
            3'd3:    cp = {5'd0, c0[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            3'd4:    cp = {c0[2:0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0]};
            default: cp = {13'd0, c0};
        endcase
    end

    // re-encode in shortest form; out of range gives an empty segment
    always_comb
    begin
        seg_cp = cp;
        if (dec.raw)
        begin
            seg_len   = 3'd1;
            seg_bytes = {24'd0, c0};
            seg_cp    = {13'd0, c0};
        end
        else if (cp <= 21'h7F)
        begin
            seg_len   = 3'd1;
            seg_bytes = {24'd0, cp[7:0]};
        end
        else if (cp <= 21'h7FF)
        begin
            seg_len   = 3'd2;
            seg_bytes = {16'd0, ucs_pkg::CONT_MARK | {2'b00, cp[5:0]},
                         ucs_pkg::LEAD2_MARK | {3'b000, cp[10:6]}};
        end
        else if (cp <= 21'hFFFF)
        begin
            seg_len   = 3'd3;
            seg_bytes = {8'd0, ucs_pkg::CONT_MARK | {2'b00, cp[5:0]},
                         ucs_pkg::CONT_MARK | {2'b00, cp[11:6]},
                         ucs_pkg::LEAD3_MARK | {4'b0000, cp[15:12]}};
        end
        else if (cp <= ucs_pkg::MAX_CODE_POINT)
        begin
            seg_len   = 3'd4;
            seg_bytes = {ucs_pkg::CONT_MARK | {2'b00, cp[5:0]},
                         ucs_pkg::CONT_MARK | {2'b00, cp[11:6]},
                         ucs_pkg::CONT_MARK | {2'b00, cp[17:12]},
                         ucs_pkg::LEAD4_MARK | {5'b00000, cp[20:18]}};
        end
        else
        begin
            seg_len   = 3'd0;
            seg_bytes = 32'd0;
        end
    end

    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            buf_next[count_reg[1:0]] = in_byte;
            count_next               = count_reg + 3'd1;
        end
        else if (cmd.step)
        begin
            buf_next   = buf_shift;
            count_next = count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            count_reg     <= 3'd0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            count_reg <= count_next;
            if (cmd.load)
                eot_reg <= in_eot;
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_len_reg   <= seg_len;
            out_bytes_reg <= seg_bytes;
            out_cp_reg    <= seg_cp;
            out_raw_reg   <= dec.raw;
            out_last_reg  <= (count_after == 3'd0) || dec_after.hold_seq;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cp_reg, out_bytes_reg, out_len_reg};
    assign m_tuser  = out_raw_reg;
    assign m_tlast  = out_last_reg;

    assign stat.hold_seq = dec.hold_seq;
    assign stat.is_last  = (count_after == 3'd0) || dec_after.hold_seq;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.eot      = eot_reg;
    assign stat.count    = count_reg;

endmodule

>>> hw/rtl/utf8_codepoint_splitter.sv
// Top level of the UTF-8 codepoint splitter: controller plus datapath.
// Depends on ucs_pkg, ucs_ctrl and ucs_datapath.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = in_byte, s_tlast = end_of_text
//  m_*      out  m_tvalid/m_tready  m_tdata = seg_len, seg_bytes, code_point;
//                                   m_tuser = raw_segment, m_tlast = last_of_run
//
// An input byte is loaded in the idle state, then evaluated; the single evaluate
// unit emits one segment per cycle while the output register is free, and a
// byte can cause 0 to 4 segments. No new byte is taken until evaluation
// returns to idle. A byte that leaves a sequence unfinished emits nothing.
// Reset clears the byte buffer and the output valid flag.
// A stalled output register holds the segment and pauses evaluation.
module utf8_codepoint_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [2:0] seg_len, [34:3] seg_bytes, [55:35] code_point
    output logic        m_tuser,    // [0] raw_segment
    output logic        m_tlast
);

    ucs_pkg::ucs_cmd_t  cmd;
    ucs_pkg::ucs_stat_t stat;

    ucs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ucs_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (s_tdata),
        .in_eot   (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    // an idle buffer holds at most an unfinished three-byte prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> stat.count <= 3'd3)
        else $error("buffer overfull while idle");

    // after the end of text the buffer is drained
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && stat.eot |-> stat.count == 3'd0)
        else $error("bytes left pending after end of text");

    // the last segment of a run returns the controller to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && stat.is_last |=> s_tready)
        else $error("controller not idle after last segment");

endmodule
